### sv/deqm_pkg.sv
// Shared constants, types and operation codes for the handle deque.
package deqm_pkg;

  localparam int CAPACITY    = 16;
  localparam int HANDLE_BITS = 32;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int IDX_W       = $clog2(CAPACITY);

  localparam logic [2:0] KIND_INS_FRONT = 3'd0;
  localparam logic [2:0] KIND_INS_BACK  = 3'd1;
  localparam logic [2:0] KIND_REM_FRONT = 3'd2;
  localparam logic [2:0] KIND_REM_BACK  = 3'd3;
  localparam logic [2:0] KIND_REM_MATCH = 3'd4;

  typedef logic [HANDLE_BITS-1:0] handle_t;

  // Operation broadcast to every cell; shr/shl only set when they can proceed.
  typedef struct packed {
    logic shr;  // insert front: every cell takes its left neighbor
    logic shl;  // remove front: every cell takes its right neighbor
    logic mrm;  // remove match: cells at and after the first hit shift left
  } deqm_ctl_t;

endpackage

### sv/deqm_cell.sv
// One slot of the deque: holds a handle, compares it, and shifts with its neighbors.
module deqm_cell
  import deqm_pkg::*;
(
  input  logic       clk_i,
  input  deqm_ctl_t  ctl_i,
  input  logic       load_i,    // this slot is the new back on insert back
  input  logic       occ_i,     // slot holds a live entry
  input  handle_t    handle_i,
  input  handle_t    left_i,
  input  handle_t    right_i,
  input  logic       pfx_i,     // a match was found in a slot nearer the front
  output logic       pfx_o,
  output handle_t    entry_q_o,
  output handle_t    entry_d_o
);

  handle_t entry_q, entry_d;
  logic    hit;

  // compare runs every cycle; only a remove-match beat acts on the prefix chain
  assign hit   = occ_i && (entry_q == handle_i);
  assign pfx_o = pfx_i | hit;

  always_comb begin
    priority if (ctl_i.shr) begin
      entry_d = left_i;
    end else if (ctl_i.shl) begin
      entry_d = right_i;
    end else if (load_i) begin
      entry_d = handle_i;
    end else if (ctl_i.mrm && pfx_o) begin
      entry_d = right_i;
    end else begin
      entry_d = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_q_o = entry_q;
  assign entry_d_o = entry_d;

endmodule

### sv/deque_with_remove_by_match.sv
// Deque of handles with remove-by-match, built as a row of shifting cells.
// Input channel: in_valid_i / in_stall_o carry kind_i and handle_i. Kinds are
// insert front, insert back, remove front, remove back, remove first match.
// Output channel: out_valid_o / out_stall_i carry one result beat per input
// beat: status_o (1 = full, empty, no match or unused kind), front_handle_o,
// back_handle_o (both 0 when empty), entry_count_o and list_empty_o, all
// taken after the operation.
// The result beat is registered and appears in the cycle after the input beat is taken.
// One beat per cycle while in_stall_o is low; every cell compares and shifts in
// the same cycle, and the first-match search ripples through the cell row.
// Reset empties the list and drops any pending result beat; slot contents
// are not cleared and are never shown before being written.
// When the receiver stalls, the result holds and in_stall_o rises so that no
// further beat is taken until the pending result drains.
module deque_with_remove_by_match
  import deqm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       kind_i,
  input  handle_t          handle_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             status_o,
  output handle_t          front_handle_o,
  output handle_t          back_handle_o,
  output logic [CNT_W-1:0] entry_count_o,
  output logic             list_empty_o
);

  logic             accept;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] cnt_m1;
  logic             full, empty, found, fail;
  logic             ldb;
  deqm_ctl_t        ctl;
  handle_t          ent_q [CAPACITY];
  handle_t          ent_d [CAPACITY];
  logic [CAPACITY:0] pfx;
  logic             out_valid_q;
  logic             status_q, empty_q;
  handle_t          front_q, back_q;
  logic [CNT_W-1:0] cnt_out_q;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign full  = (count_q == CNT_W'(CAPACITY));
  assign empty = (count_q == '0);
  assign found = pfx[CAPACITY];

  always_comb begin
    ctl     = '0;
    ldb     = 1'b0;
    fail    = 1'b1;
    count_d = count_q;
    if (accept) begin
      unique case (kind_i)
        KIND_INS_FRONT: begin
          ctl.shr = ~full;
          fail    = full;
          if (!full) count_d = count_q + CNT_W'(1);
        end
        KIND_INS_BACK: begin
          ldb  = ~full;
          fail = full;
          if (!full) count_d = count_q + CNT_W'(1);
        end
        KIND_REM_FRONT: begin
          ctl.shl = ~empty;
          fail    = empty;
          if (!empty) count_d = count_q - CNT_W'(1);
        end
        KIND_REM_BACK: begin
          fail = empty;
          if (!empty) count_d = count_q - CNT_W'(1);
        end
        KIND_REM_MATCH: begin
          ctl.mrm = 1'b1;
          fail    = ~found;
          if (found) count_d = count_q - CNT_W'(1);
        end
        default: begin
          fail = 1'b1;
        end
      endcase
    end
  end

  assign pfx[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic    occ, load;
    handle_t left, right;

    assign occ   = (CNT_W'(i) < count_q);
    assign load  = ldb && (count_q == CNT_W'(i));
    assign left  = (i == 0) ? handle_i : ent_q[(i == 0) ? 0 : i - 1];
    assign right = (i == CAPACITY - 1) ? ent_q[i] : ent_q[(i == CAPACITY - 1) ? i : i + 1];

    deqm_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .load_i    (load),
      .occ_i     (occ),
      .handle_i  (handle_i),
      .left_i    (left),
      .right_i   (right),
      .pfx_i     (pfx[i]),
      .pfx_o     (pfx[i+1]),
      .entry_q_o (ent_q[i]),
      .entry_d_o (ent_d[i])
    );
  end

  assign cnt_m1 = IDX_W'(count_d - CNT_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= fail;
      cnt_out_q <= count_d;
      empty_q   <= (count_d == '0);
      front_q   <= (count_d == '0) ? '0 : ent_d[0];
      back_q    <= (count_d == '0) ? '0 : ent_d[cnt_m1];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign front_handle_o = front_q;
  assign back_handle_o  = back_q;
  assign entry_count_o  = cnt_out_q;
  assign list_empty_o   = empty_q;

endmodule
